### hw/rtl/lsmt_pkg.sv
package lsmt_pkg;

  // Default line length in clock cycles
  localparam int unsigned LineCyclesDef = 456;

  // Frame geometry and mode boundaries within a line
  localparam int unsigned LinesPerFrame = 154;
  localparam int unsigned VblankLine    = 144;
  localparam int unsigned OamEnd        = 80;
  localparam int unsigned TransferEnd   = 252;

  localparam int unsigned CyclesW  = 8;
  localparam int unsigned LineW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DISPLAY_EN  = 3'd0,
    CFG_HBLANK_EN   = 3'd1,
    CFG_VBLANK_EN   = 3'd2,
    CFG_OAM_EN      = 3'd3,
    CFG_COMPARE_EN  = 3'd4,
    CFG_LINE_CMP    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic             display_enable;
    logic             hblank_request_enable;
    logic             vblank_request_enable;
    logic             oam_request_enable;
    logic             compare_request_enable;
    logic [LineW-1:0] line_compare;
  } cfg_t;

  typedef struct packed {
    logic [LineW-1:0] line_index;
    mode_e            mode;
    logic             coincidence;
    logic             vblank_request;
    logic             status_request;
  } result_t;

endpackage

### hw/rtl/lsmt_if.sv
interface lsmt_in_if;
  logic                         valid;
  logic                         ready;
  logic [lsmt_pkg::CyclesW-1:0] cycles;

  modport source (output valid, output cycles, input ready);
  modport sink   (input valid, input cycles, output ready);
endinterface

interface lsmt_out_if;
  logic                       valid;
  logic                       ready;
  logic [lsmt_pkg::LineW-1:0] line_index;
  logic [1:0]                 mode;
  logic                       coincidence;
  logic                       vblank_request;
  logic                       status_request;

  modport source (output valid, output line_index, output mode, output coincidence,
                  output vblank_request, output status_request, input ready);
  modport sink   (input valid, input line_index, input mode, input coincidence,
                  input vblank_request, input status_request, output ready);
endinterface

interface lsmt_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lsmt_pkg::CfgIdxW-1:0]  index;
  logic [lsmt_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/lsmt_cfg_regs.sv
module lsmt_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  lsmt_cfg_if.sink       cfg_i,
  output lsmt_pkg::cfg_t cfg_o
);
  import lsmt_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_DISPLAY_EN: cfg_d.display_enable         = cfg_i.data[0];
        CFG_HBLANK_EN:  cfg_d.hblank_request_enable  = cfg_i.data[0];
        CFG_VBLANK_EN:  cfg_d.vblank_request_enable  = cfg_i.data[0];
        CFG_OAM_EN:     cfg_d.oam_request_enable     = cfg_i.data[0];
        CFG_COMPARE_EN: cfg_d.compare_request_enable = cfg_i.data[0];
        CFG_LINE_CMP:   cfg_d.line_compare           = cfg_i.data[LineW-1:0];
        default:        ; // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/lsmt_step.sv
module lsmt_step #(
  parameter int unsigned LINE_CYCLES = lsmt_pkg::LineCyclesDef,
  parameter int unsigned PosW        = $clog2(LINE_CYCLES)
) (
  input  lsmt_pkg::cfg_t                 cfg_i,
  input  logic [lsmt_pkg::CyclesW-1:0]   cycles_i,
  input  logic [PosW-1:0]                pos_i,
  input  logic [lsmt_pkg::LineW-1:0]     line_i,
  input  lsmt_pkg::mode_e                mode_i,
  input  logic                           match_i,
  output logic [PosW-1:0]                pos_o,
  output lsmt_pkg::result_t              res_o
);
  import lsmt_pkg::*;

  localparam int unsigned SumW = PosW + 1;
  localparam logic [SumW-1:0] LineLen = SumW'(LINE_CYCLES);

  logic [SumW-1:0]  sum, sum1, sum2;
  logic             wrap;
  logic [LineW-1:0] line_inc, line_n;
  logic [PosW-1:0]  pos_n;
  mode_e            mode_n;
  logic             req_en, line_hit;

  always_comb begin
    sum  = {1'b0, pos_i} + SumW'(cycles_i);
    wrap = (sum >= LineLen);
    sum1 = wrap ? (sum - LineLen) : sum;
    // short lines: the sum can reach twice the line length
    sum2 = (sum1 >= LineLen) ? (sum1 - LineLen) : sum1;
    pos_n = sum2[PosW-1:0];

    line_inc = (line_i == LineW'(LinesPerFrame - 1)) ? '0 : (line_i + 1'b1);
    line_n   = wrap ? line_inc : line_i;
    line_hit = (line_n == cfg_i.line_compare);

    if (line_n >= LineW'(VblankLine)) begin
      mode_n = MODE_VBLANK;
      req_en = cfg_i.vblank_request_enable;
    end else if (pos_n < PosW'(OamEnd)) begin
      mode_n = MODE_OAM;
      req_en = cfg_i.oam_request_enable;
    end else if (pos_n < PosW'(TransferEnd)) begin
      mode_n = MODE_XFER;
      req_en = 1'b0;
    end else begin
      mode_n = MODE_HBLANK;
      req_en = cfg_i.hblank_request_enable;
    end

    if (cfg_i.display_enable) begin
      pos_o                = pos_n;
      res_o.line_index     = line_n;
      res_o.mode           = mode_n;
      res_o.coincidence    = wrap ? line_hit : match_i;
      res_o.vblank_request = wrap && (line_n == LineW'(VblankLine));
      res_o.status_request = ((mode_n != mode_i) && req_en) ||
                             (wrap && line_hit && cfg_i.compare_request_enable);
    end else begin
      // display off: counters parked, vblank mode, flag kept
      pos_o                = '0;
      res_o.line_index     = '0;
      res_o.mode           = MODE_VBLANK;
      res_o.coincidence    = match_i;
      res_o.vblank_request = 1'b0;
      res_o.status_request = 1'b0;
    end
  end

endmodule

### hw/rtl/lcd_scanline_mode_timing_unit.sv
// LCD scanline and mode timing unit.
//
// in_i carries one item per elapsed-cycle count; each item yields exactly one
// result item on out_o: line index, mode, coincidence flag and the vblank and
// status request pulses for that step. cfg_i writes the six control registers
// by index; writes are always taken (ready tied high), unmapped indexes drop.
// Registers should only be written while no item is in flight.
//
// An accepted item sits in the input register; its result is loaded into the
// output register when that register is free or being drained, and
// out_o.valid rises with that load and stays high until the result is taken.
// Throughput: one item per cycle while results are taken. The timing state
// (line position, line, mode, flag) is updated in the same cycle the result
// is registered, so the next item sees it at once.
// Stall: while out_o holds a result that is not taken, the input register can
// still accept one item; in_i.ready drops once both are occupied.
// Reset: counters, flags, valid and config regs clear; mode resets to hblank.
module lcd_scanline_mode_timing_unit #(
  parameter int unsigned LINE_CYCLES = lsmt_pkg::LineCyclesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lsmt_in_if.sink     in_i,
  lsmt_out_if.source  out_o,
  lsmt_cfg_if.sink    cfg_i
);
  import lsmt_pkg::*;

  localparam int unsigned PosW = $clog2(LINE_CYCLES);

  cfg_t cfg;

  // input stage
  logic               in_valid_q;
  logic [CyclesW-1:0] cycles_q;

  // timing state
  logic [PosW-1:0]  pos_q, pos_d;
  logic [LineW-1:0] line_q;
  mode_e            mode_q;
  logic             match_q;

  // output stage
  logic    out_valid_q;
  result_t res_q, res_d;

  logic advance;

  lsmt_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  lsmt_step #(
    .LINE_CYCLES (LINE_CYCLES),
    .PosW        (PosW)
  ) u_step (
    .cfg_i    (cfg),
    .cycles_i (cycles_q),
    .pos_i    (pos_q),
    .line_i   (line_q),
    .mode_i   (mode_q),
    .match_i  (match_q),
    .pos_o    (pos_d),
    .res_o    (res_d)
  );

  // Result register loads when an item waits and it is empty or being drained
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      line_q      <= '0;
      mode_q      <= MODE_HBLANK;
      match_q     <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        pos_q       <= pos_d;
        line_q      <= res_d.line_index;
        mode_q      <= res_d.mode;
        match_q     <= res_d.coincidence;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      cycles_q <= in_i.cycles;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.line_index     = res_q.line_index;
  assign out_o.mode           = res_q.mode;
  assign out_o.coincidence    = res_q.coincidence;
  assign out_o.vblank_request = res_q.vblank_request;
  assign out_o.status_request = res_q.status_request;

endmodule

### sim/tb.sv
module tb;
  import lsmt_pkg::*;

  localparam int unsigned LineLen       = LineCyclesDef;
  localparam int unsigned MaxGap        = 13;
  localparam int unsigned LongHold      = 150;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned ShowLimit     = 10;

  // Indexes past the register map; writes there must be dropped
  localparam logic [CfgIdxW-1:0] IdxSpareLo = CfgIdxW'(CFG_LINE_CMP + 1);
  localparam logic [CfgIdxW-1:0] IdxSpareHi = CfgIdxW'(CFG_LINE_CMP + 2);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lsmt_in_if  in_if ();
  lsmt_out_if out_if ();
  lsmt_cfg_if cfg_if ();

  lcd_scanline_mode_timing_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Timing model: config copy plus line position, line, mode and match flag
  cfg_t             lcd_cfg   = '0;
  logic [9:0]       line_pos  = '0;
  logic [LineW-1:0] line_idx  = '0;
  mode_e            last_mode = MODE_HBLANK;
  logic             match_flg = 1'b0;

  logic [CyclesW-1:0] cycle_counts_q[$];
  result_t            timing_expect_q[$];

  bit in_idle_on  = 1'b1;
  bit out_idle_on = 1'b1;
  int hold_token  = 0;
  int errors      = 0;
  int shown       = 0;

  function automatic result_t advance_timing(input logic [CyclesW-1:0] cyc);
    result_t     r;
    int unsigned sum;
    logic        new_line;
    logic        req_en;
    mode_e       m;
    r        = '0;
    new_line = 1'b0;
    if (!lcd_cfg.display_enable) begin
      // display off: counters clear, vblank forced, flag kept, no requests
      line_pos  = '0;
      line_idx  = '0;
      last_mode = MODE_VBLANK;
    end else begin
      sum = line_pos + cyc;
      if (sum >= LineLen) begin
        sum      = sum % LineLen;
        line_idx = LineW'((int'(line_idx) + 1) % LinesPerFrame);
        r.vblank_request = (line_idx == VblankLine);
        new_line = 1'b1;
      end
      line_pos = 10'(sum);
      if (line_idx >= VblankLine) begin
        m      = MODE_VBLANK;
        req_en = lcd_cfg.vblank_request_enable;
      end else if (line_pos < OamEnd) begin
        m      = MODE_OAM;
        req_en = lcd_cfg.oam_request_enable;
      end else if (line_pos < TransferEnd) begin
        m      = MODE_XFER;
        req_en = 1'b0;
      end else begin
        m      = MODE_HBLANK;
        req_en = lcd_cfg.hblank_request_enable;
      end
      if (m != last_mode && req_en) r.status_request = 1'b1;
      // coincidence is only re-evaluated when a line starts
      if (new_line) begin
        match_flg = (line_idx == lcd_cfg.line_compare);
        if (match_flg && lcd_cfg.compare_request_enable) r.status_request = 1'b1;
      end
      last_mode = m;
    end
    r.line_index  = line_idx;
    r.mode        = last_mode;
    r.coincidence = match_flg;
    return r;
  endfunction

  function automatic int unsigned draw_gap(input bit idle_on);
    return idle_on ? $urandom_range(0, MaxGap) : 0;
  endfunction

  // Mostly near-full counts so lines wrap often; some anywhere, some tiny
  function automatic logic [CyclesW-1:0] random_cycles();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return CyclesW'($urandom_range(180, 255));
    else if (pick < 85) return CyclesW'($urandom);
    else return CyclesW'($urandom_range(0, 15));
  endfunction

  // Input driver
  int unsigned in_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin : drive_cycles
    if (!rst_ni) begin
      in_if.valid  <= 1'b0;
      in_if.cycles <= '0;
      in_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        timing_expect_q.insert(timing_expect_q.size(), advance_timing(in_if.cycles));
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (cycle_counts_q.size() > 0) begin
          in_if.valid  <= 1'b1;
          in_if.cycles <= cycle_counts_q.pop_front();
          in_gap = draw_gap(in_idle_on);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor and checker
  int unsigned out_stall = 0;
  int unsigned hold_left = 0;
  int          hold_seen = 0;

  always @(posedge clk_i or negedge rst_ni) begin : check_results
    result_t exp_r;
    bit      bad;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_stall = 0;
      hold_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (timing_expect_q.size() == 0) begin
          errors++;
          if (shown < ShowLimit) begin
            shown++;
            $display("unexpected item: line=%0d mode=%0d coin=%b vb=%b st=%b",
                     out_if.line_index, out_if.mode, out_if.coincidence,
                     out_if.vblank_request, out_if.status_request);
          end
        end else begin
          exp_r = timing_expect_q.pop_front();
          bad = (out_if.line_index != exp_r.line_index) ||
                (out_if.mode != exp_r.mode) ||
                (out_if.coincidence != exp_r.coincidence) ||
                (out_if.vblank_request != exp_r.vblank_request) ||
                (out_if.status_request != exp_r.status_request);
          if (bad) begin
            errors++;
            if (shown < ShowLimit) begin
              shown++;
              $display("mismatch: exp line=%0d mode=%0d coin=%b vb=%b st=%b",
                       exp_r.line_index, exp_r.mode, exp_r.coincidence,
                       exp_r.vblank_request, exp_r.status_request);
              $display("          got line=%0d mode=%0d coin=%b vb=%b st=%b",
                       out_if.line_index, out_if.mode, out_if.coincidence,
                       out_if.vblank_request, out_if.status_request);
            end
          end
        end
        out_stall = draw_gap(out_idle_on);
      end
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted item
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_DISPLAY_EN: lcd_cfg.display_enable         = val[0];
      CFG_HBLANK_EN:  lcd_cfg.hblank_request_enable  = val[0];
      CFG_VBLANK_EN:  lcd_cfg.vblank_request_enable  = val[0];
      CFG_OAM_EN:     lcd_cfg.oam_request_enable     = val[0];
      CFG_COMPARE_EN: lcd_cfg.compare_request_enable = val[0];
      CFG_LINE_CMP:   lcd_cfg.line_compare           = val;
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  // Flag registers get junk in the upper data bits; only bit 0 counts
  function automatic logic [CfgDataW-1:0] flag_data(input bit f);
    return {CfgDataW'($urandom) & ~CfgDataW'(1)} | CfgDataW'(f);
  endfunction

  task automatic set_config(input bit de, input bit he, input bit ve, input bit oe,
                            input bit ce, input logic [LineW-1:0] cmp);
    write_reg(CFG_DISPLAY_EN, flag_data(de));
    write_reg(CFG_HBLANK_EN, flag_data(he));
    write_reg(CFG_VBLANK_EN, flag_data(ve));
    write_reg(CFG_OAM_EN, flag_data(oe));
    write_reg(CFG_COMPARE_EN, flag_data(ce));
    write_reg(CFG_LINE_CMP, cmp);
    if ($urandom_range(0, 1)) write_reg(IdxSpareLo, CfgDataW'($urandom));
    else write_reg(IdxSpareHi, CfgDataW'($urandom));
  endtask

  // Sender pause: nothing more goes out until every result is back
  task automatic wait_drain();
    do @(posedge clk_i);
    while (cycle_counts_q.size() != 0 || in_if.valid || timing_expect_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic queue_count(input logic [CyclesW-1:0] c);
    cycle_counts_q.insert(cycle_counts_q.size(), c);
  endtask

  task automatic push_random(input int n);
    repeat (n) queue_count(random_cycles());
  endtask

  task automatic random_phase(input bit de, input logic [LineW-1:0] cmp, input int n,
                              input bit idle_in, input bit idle_out);
    wait_drain();
    set_config(de, bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)),
               bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)), cmp);
    in_idle_on  = idle_in;
    out_idle_on = idle_out;
    push_random(n);
  endtask

  initial begin : sequencer
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= '0;
    cfg_if.data   <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // display off straight out of reset: mode forced to vblank
    queue_count(CyclesW'(0));
    queue_count(CyclesW'(255));
    queue_count(CyclesW'(128));

    // walk the mode boundaries of one line, then wrap onto line 1 == compare
    wait_drain();
    set_config(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, LineW'(1));
    queue_count(CyclesW'(0));
    queue_count(CyclesW'(79));
    queue_count(CyclesW'(1));
    queue_count(CyclesW'(171));
    queue_count(CyclesW'(1));
    queue_count(CyclesW'(203));
    queue_count(CyclesW'(1));
    queue_count(CyclesW'(255));
    queue_count(CyclesW'(255));
    queue_count(CyclesW'(255));
    queue_count(CyclesW'(200));
    queue_count(CyclesW'(0));

    // display off mid-frame keeps the coincidence flag, then back on
    wait_drain();
    write_reg(CFG_DISPLAY_EN, flag_data(1'b0));
    queue_count(CyclesW'(5));
    wait_drain();
    write_reg(CFG_DISPLAY_EN, flag_data(1'b1));
    queue_count(CyclesW'(255));
    queue_count(CyclesW'(128));

    // random phases, extremes of the compare value among them
    wait_drain();
    set_config(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, LineW'(VblankLine));
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    push_random(110);

    wait_drain();
    set_config(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, LineW'(255));
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    push_random(100);

    // receiver holds off while the sender keeps pushing: input backs up
    wait_drain();
    set_config(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, LineW'(0));
    in_idle_on  = 1'b0;
    out_idle_on = 1'b1;
    hold_token++;
    push_random(100);

    random_phase(1'b0, LineW'($urandom), 40, 1'b1, 1'b1);
    random_phase(1'b1, LineW'(LinesPerFrame - 1), 100, 1'b1, 1'b0);
    random_phase(1'b1, LineW'($urandom_range(0, LinesPerFrame - 1)), 100, 1'b0, 1'b0);
    random_phase(1'b1, LineW'($urandom), 100, 1'b1, 1'b1);
    random_phase(1'b1, LineW'($urandom_range(0, LinesPerFrame - 1)), 100, 1'b0, 1'b1);
    random_phase(1'b1, LineW'($urandom_range(0, LinesPerFrame - 1)), 100, 1'b1, 1'b1);

    wait_drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && timing_expect_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/lsmt_pkg.sv
hw/rtl/lsmt_if.sv
hw/rtl/lsmt_cfg_regs.sv
hw/rtl/lsmt_step.sv
hw/rtl/lcd_scanline_mode_timing_unit.sv
sim/tb.sv
